>>> sv/w2s_pkg.sv
// types and constants shared by the world-to-screen projection block
// no dependencies
package w2s_pkg;

  // coordinate difference, camera-space value and rotation term widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned RotW   = 16;
  localparam int unsigned DimW   = 13;
  localparam int unsigned CamW   = 36;  // camera-space x, y, z after rotation
  localparam int unsigned FracW  = 16;
  localparam int unsigned RotFrac = 14;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CAM_POS_X     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAM_POS_Y     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAM_POS_Z     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROT_COS       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROT_SIN       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] world_x;
    logic signed [CoordW-1:0] world_y;
    logic signed [CoordW-1:0] world_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic                     behind_camera;
  } result_t;

  // sideband that rides along the divider chain
  typedef struct packed {
    logic valid;
    logic behind;
    logic neg_x;
    logic neg_y;
  } div_ctl_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cam_pos_x;
    logic signed [CoordW-1:0] cam_pos_y;
    logic signed [CoordW-1:0] cam_pos_z;
    logic signed [RotW-1:0]   rot_cos;
    logic signed [RotW-1:0]   rot_sin;
  } xform_cfg_t;

endpackage

>>> sv/world_to_screen_projection_core.sv
// top level of the pinhole world-to-screen projector
// depends on w2s_pkg, w2s_xform, w2s_div_cell
//
// Takes one world point per clock whenever start_i is high (busy_o stays low)
// and delivers its screen position on result_o, marked by done_o for one cycle,
// after four front-end stages, N = 52 + clog2(SCALE+1) division cells (61 at
// SCALE = 300) of one quotient bit each and one output register. There is no
// back-pressure; the receiver must take every result as it appears. Points at
// or behind the camera plane come out as zero with behind_camera set.
// Configuration writes are always taken and belong in quiet periods.
module world_to_screen_projection_core #(
  parameter int unsigned SCALE = 300
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  w2s_pkg::point_t               point_i,
  output logic                          done_o,
  output w2s_pkg::result_t              result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [w2s_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [w2s_pkg::CoordW-1:0]    cfg_data_i
);
  import w2s_pkg::*;

  localparam int unsigned ScaleW = $clog2(SCALE + 1);
  localparam int unsigned NumW   = CamW + ScaleW + FracW;
  localparam int unsigned ResW   = NumW + 2;
  localparam int unsigned Lat    = 4 + NumW + 1;

  xform_cfg_t           xcfg_q;
  logic [DimW-1:0]      width_q, height_q;

  div_ctl_t             ctl   [0:NumW];
  logic [CamW-1:0]      den   [0:NumW];
  logic [CamW-1:0]      rem_x [0:NumW];
  logic [CamW-1:0]      rem_y [0:NumW];
  logic [NumW-1:0]      nq_x  [0:NumW];
  logic [NumW-1:0]      nq_y  [0:NumW];

  logic signed [ResW-1:0] half_w, half_h, sx, sy;
  logic signed [ResW-1:0] qx, qy;
  logic                   done_q;
  result_t                res_d, res_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xcfg_q.cam_pos_x <= '0;
      xcfg_q.cam_pos_y <= '0;
      xcfg_q.cam_pos_z <= '0;
      xcfg_q.rot_cos   <= RotW'(16384);
      xcfg_q.rot_sin   <= '0;
      width_q          <= DimW'(800);
      height_q         <= DimW'(600);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CAM_POS_X:     xcfg_q.cam_pos_x <= cfg_data_i;
        CFG_CAM_POS_Y:     xcfg_q.cam_pos_y <= cfg_data_i;
        CFG_CAM_POS_Z:     xcfg_q.cam_pos_z <= cfg_data_i;
        CFG_ROT_COS:       xcfg_q.rot_cos   <= cfg_data_i[RotW-1:0];
        CFG_ROT_SIN:       xcfg_q.rot_sin   <= cfg_data_i[RotW-1:0];
        CFG_SCREEN_WIDTH:  width_q          <= cfg_data_i[DimW-1:0];
        CFG_SCREEN_HEIGHT: height_q         <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  w2s_xform #(
    .NumW   (NumW),
    .ScaleW (ScaleW),
    .SCALE  (SCALE)
  ) u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy_o),
    .point_i (point_i),
    .cfg_i   (xcfg_q),
    .ctl_o   (ctl[0]),
    .den_o   (den[0]),
    .num_x_o (nq_x[0]),
    .num_y_o (nq_y[0])
  );

  assign rem_x[0] = '0;
  assign rem_y[0] = '0;

  for (genvar i = 0; i < NumW; i++) begin : g_cell
    w2s_div_cell #(.NumW(NumW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[i]),
      .den_i   (den[i]),
      .rem_x_i (rem_x[i]),
      .rem_y_i (rem_y[i]),
      .nq_x_i  (nq_x[i]),
      .nq_y_i  (nq_y[i]),
      .ctl_o   (ctl[i+1]),
      .den_o   (den[i+1]),
      .rem_x_o (rem_x[i+1]),
      .rem_y_o (rem_y[i+1]),
      .nq_x_o  (nq_x[i+1]),
      .nq_y_o  (nq_y[i+1])
    );
  end

  // half a screen dimension in Q16.16, then saturate the signed sum
  always_comb begin
    half_w = ResW'({width_q, 15'd0});
    half_h = ResW'({height_q, 15'd0});
    qx = ctl[NumW].neg_x ? -ResW'(nq_x[NumW]) : ResW'(nq_x[NumW]);
    qy = ctl[NumW].neg_y ? -ResW'(nq_y[NumW]) : ResW'(nq_y[NumW]);
    sx = half_w - qx;
    sy = half_h + qy;
    if (sx > ResW'(32'sh7fffffff)) begin
      res_d.screen_x = 32'sh7fffffff;
    end else if (sx < -ResW'(64'sh80000000)) begin
      res_d.screen_x = 32'sh80000000;
    end else begin
      res_d.screen_x = sx[CoordW-1:0];
    end
    if (sy > ResW'(32'sh7fffffff)) begin
      res_d.screen_y = 32'sh7fffffff;
    end else if (sy < -ResW'(64'sh80000000)) begin
      res_d.screen_y = 32'sh80000000;
    end else begin
      res_d.screen_y = sy[CoordW-1:0];
    end
    res_d.behind_camera = ctl[NumW].behind;
    if (ctl[NumW].behind) begin
      res_d.screen_x = '0;
      res_d.screen_y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl[NumW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every accepted point comes out after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat done_o)
    else $error("point accepted but no result after the pipeline latency");

  // no result without a point accepted the pipeline latency earlier
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##Lat done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result beat without a matching input beat");

  // behind-camera beats carry zero coordinates
  a_behind_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.behind_camera |->
      (result_o.screen_x == '0) && (result_o.screen_y == '0))
    else $error("behind-camera result with nonzero coordinates");

endmodule

>>> sv/w2s_xform.sv
// front end: camera offset, rotation about the vertical axis, divider operands
// depends on w2s_pkg
module w2s_xform #(
  parameter int unsigned NumW  = 61,
  parameter int unsigned ScaleW = 9,
  parameter int unsigned SCALE = 300
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  w2s_pkg::point_t              point_i,
  input  w2s_pkg::xform_cfg_t          cfg_i,
  output w2s_pkg::div_ctl_t            ctl_o,
  output logic [w2s_pkg::CamW-1:0]     den_o,
  output logic [NumW-1:0]              num_x_o,
  output logic [NumW-1:0]              num_y_o
);
  import w2s_pkg::*;

  localparam int unsigned ProdW = RotW + DiffW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned MagW  = CamW + ScaleW;

  logic                    v1_q, v2_q, v3_q, v4_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q, dy2_q;
  logic signed [ProdW-1:0] cdx_q, sdz_q, cdz_q, sdx_q;
  logic signed [CamW-1:0]  cx_q, cy_q, cz_q;
  logic signed [SumW-1:0]  sum_x, sum_z;
  logic [CamW-1:0]         mag_x, mag_y, mag_z;
  logic [MagW-1:0]         sc_x, sc_y;
  div_ctl_t                ctl_d, ctl_q;
  logic [CamW-1:0]         den_q;
  logic [NumW-1:0]         num_x_q, num_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign sum_x = SumW'(cdx_q) + SumW'(sdz_q);
  assign sum_z = SumW'(cdz_q) - SumW'(sdx_q);

  always_comb begin
    mag_x = cx_q[CamW-1] ? CamW'(-cx_q) : CamW'(cx_q);
    mag_y = cy_q[CamW-1] ? CamW'(-cy_q) : CamW'(cy_q);
    mag_z = CamW'(-cz_q);
    sc_x  = MagW'(mag_x) * MagW'(SCALE);
    sc_y  = MagW'(mag_y) * MagW'(SCALE);
    ctl_d.valid  = v3_q;
    ctl_d.behind = !cz_q[CamW-1];
    // cz is negative here, so the quotient sign is the inverse of the numerator sign
    ctl_d.neg_x  = !cx_q[CamW-1];
    ctl_d.neg_y  = !cy_q[CamW-1];
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= DiffW'(point_i.world_x) - DiffW'(cfg_i.cam_pos_x);
    dy_q  <= DiffW'(point_i.world_y) - DiffW'(cfg_i.cam_pos_y);
    dz_q  <= DiffW'(point_i.world_z) - DiffW'(cfg_i.cam_pos_z);
    cdx_q <= ProdW'(cfg_i.rot_cos) * ProdW'(dx_q);
    sdz_q <= ProdW'(cfg_i.rot_sin) * ProdW'(dz_q);
    cdz_q <= ProdW'(cfg_i.rot_cos) * ProdW'(dz_q);
    sdx_q <= ProdW'(cfg_i.rot_sin) * ProdW'(dx_q);
    dy2_q <= dy_q;
    // arithmetic shift floors toward minus infinity
    cx_q  <= sum_x[RotFrac +: CamW];
    cz_q  <= sum_z[RotFrac +: CamW];
    cy_q  <= CamW'(dy2_q);
    ctl_q   <= ctl_d;
    den_q   <= mag_z;
    num_x_q <= {sc_x, {FracW{1'b0}}};
    num_y_q <= {sc_y, {FracW{1'b0}}};
  end

  always_comb begin
    ctl_o       = ctl_q;
    ctl_o.valid = v4_q;
  end
  assign den_o   = den_q;
  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;

endmodule

>>> sv/w2s_div_cell.sv
// one restoring-division cell: one quotient bit for the x and y lanes
// depends on w2s_pkg
module w2s_div_cell #(
  parameter int unsigned NumW = 61
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  w2s_pkg::div_ctl_t        ctl_i,
  input  logic [w2s_pkg::CamW-1:0] den_i,
  input  logic [w2s_pkg::CamW-1:0] rem_x_i,
  input  logic [w2s_pkg::CamW-1:0] rem_y_i,
  input  logic [NumW-1:0]          nq_x_i,
  input  logic [NumW-1:0]          nq_y_i,
  output w2s_pkg::div_ctl_t        ctl_o,
  output logic [w2s_pkg::CamW-1:0] den_o,
  output logic [w2s_pkg::CamW-1:0] rem_x_o,
  output logic [w2s_pkg::CamW-1:0] rem_y_o,
  output logic [NumW-1:0]          nq_x_o,
  output logic [NumW-1:0]          nq_y_o
);
  import w2s_pkg::*;

  logic [CamW:0]   trial_x, trial_y, dext;
  logic            ge_x, ge_y;
  logic [CamW:0]   diff_x, diff_y;
  logic            valid_q;
  div_ctl_t        ctl_q;
  logic [CamW-1:0] den_q, rem_x_q, rem_y_q;
  logic [NumW-1:0] nq_x_q, nq_y_q;

  // numerator bits leave at the top while quotient bits enter at the bottom
  always_comb begin
    dext    = {1'b0, den_i};
    trial_x = {rem_x_i, nq_x_i[NumW-1]};
    trial_y = {rem_y_i, nq_y_i[NumW-1]};
    ge_x    = trial_x >= dext;
    ge_y    = trial_y >= dext;
    diff_x  = ge_x ? trial_x - dext : trial_x;
    diff_y  = ge_y ? trial_y - dext : trial_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q   <= ctl_i;
    den_q   <= den_i;
    rem_x_q <= diff_x[CamW-1:0];
    rem_y_q <= diff_y[CamW-1:0];
    nq_x_q  <= {nq_x_i[NumW-2:0], ge_x};
    nq_y_q  <= {nq_y_i[NumW-2:0], ge_y};
  end

  always_comb begin
    ctl_o       = ctl_q;
    ctl_o.valid = valid_q;
  end
  assign den_o   = den_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign nq_x_o  = nq_x_q;
  assign nq_y_o  = nq_y_q;

endmodule
